@@ hw/rtl/psu_pkg.sv @@
`default_nettype none

package psu_pkg;

   // Storage sizes
   localparam int ROW_BYTES_MAX   = 8192;
   localparam int PIXEL_BYTES_MAX = 8;

   // Field and register widths
   localparam int BYTE_W = 8;
   localparam int BPP_W  = 4;
   localparam int LEN_W  = 14;
   localparam int COL_W  = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
   localparam int CNT_W  = $clog2(ROW_BYTES_MAX + 1);
   localparam int HIST_W = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;

   // Register indexes on the csr port
   localparam logic CSR_BPP = 1'b0;
   localparam logic CSR_LEN = 1'b1;

   // Highest valid filter code on the wire
   localparam logic [BYTE_W-1:0] FILTER_CODE_MAX = 8'd4;

   // Row filter, with one code for an invalid filter byte
   typedef enum logic [2:0] {
      FILT_NONE,
      FILT_SUB,
      FILT_UP,
      FILT_AVG,
      FILT_PAETH,
      FILT_BAD
   } filt_code_type;

   // One request held between the row control and the reconstruction stage
   typedef struct packed {
      logic              is_data;
      logic              clear_hist;
      logic              first_row;
      logic              last;
      filt_code_type     filt;
      logic [COL_W-1:0]  col;
      logic [BYTE_W-1:0] data;
   } item_type;

endpackage

`default_nettype wire

@@ hw/rtl/psu_above_ram.sv @@
`default_nettype none

module psu_above_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [psu_pkg::COL_W-1:0]  wr_addr,
   input  wire logic [psu_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [psu_pkg::COL_W-1:0]  rd_addr,
   output logic      [psu_pkg::BYTE_W-1:0] rd_data_ff
);

   logic [psu_pkg::BYTE_W-1:0] mem [psu_pkg::ROW_BYTES_MAX];

   // Write the reconstructed byte back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psu_row_ctrl.sv @@
`default_nettype none

module psu_row_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [psu_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                       req_first_of_image,
   output logic                            req_stall,
   input  wire logic [psu_pkg::LEN_W-1:0]  row_length,
   input  wire logic                       advance,
   output logic                            item_valid_ff,
   output psu_pkg::item_type               item_ff,
   output logic                            rd_en,
   output logic [psu_pkg::COL_W-1:0]       rd_addr
);

   logic [psu_pkg::CNT_W-1:0] col_cnt_ff, col_cnt_in, col_cnt_eff;
   logic                      first_row_ff, first_row_in, first_row_eff;
   psu_pkg::filt_code_type    row_filter_ff, row_filter_in;
   logic                      item_valid_in;
   psu_pkg::item_type         item_in;
   logic [psu_pkg::CNT_W-1:0] len_eff;
   logic [psu_pkg::CNT_W-1:0] col_next;
   logic                      accept;

   // The stage takes a request whenever none is held or its held one moves on
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Clamp the row length to 1 .. ROW_BYTES_MAX
   always_comb begin
      if (row_length == '0) begin
         len_eff = psu_pkg::CNT_W'(1);
      end else if (psu_pkg::CNT_W'(row_length) > psu_pkg::CNT_W'(psu_pkg::ROW_BYTES_MAX)) begin
         len_eff = psu_pkg::CNT_W'(psu_pkg::ROW_BYTES_MAX);
      end else begin
         len_eff = psu_pkg::CNT_W'(row_length);
      end
   end

   // Column bookkeeping and request capture
   always_comb begin
      col_cnt_eff   = req_first_of_image ? '0 : col_cnt_ff;
      first_row_eff = req_first_of_image ? 1'b1 : first_row_ff;
      col_next      = col_cnt_eff;

      col_cnt_in    = col_cnt_ff;
      first_row_in  = first_row_ff;
      row_filter_in = row_filter_ff;

      item_in.is_data    = (col_cnt_eff != '0);
      item_in.clear_hist = req_first_of_image;
      item_in.first_row  = first_row_eff;
      item_in.filt       = row_filter_ff;
      item_in.col        = psu_pkg::COL_W'(col_cnt_eff - psu_pkg::CNT_W'(1));
      item_in.last       = (col_next >= len_eff);
      item_in.data       = req_data_byte;

      if (accept) begin
         if (col_cnt_eff == '0) begin
            // filter byte opens the row
            if (req_data_byte > psu_pkg::FILTER_CODE_MAX) begin
               row_filter_in = psu_pkg::FILT_BAD;
            end else begin
               row_filter_in = psu_pkg::filt_code_type'(req_data_byte[2:0]);
            end
            col_cnt_in   = psu_pkg::CNT_W'(1);
            first_row_in = first_row_eff;
         end else if (item_in.last) begin
            col_cnt_in   = '0;
            first_row_in = 1'b0;
         end else begin
            col_cnt_in   = col_cnt_eff + psu_pkg::CNT_W'(1);
            first_row_in = first_row_eff;
         end
      end
   end

   // Fetch the byte above for data requests only
   assign rd_en   = accept && item_in.is_data;
   assign rd_addr = item_in.col;

   // Hold the request until the reconstruction stage takes it
   always_comb begin
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff    <= '0;
         first_row_ff  <= 1'b1;
         row_filter_ff <= psu_pkg::FILT_NONE;
         item_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff    <= col_cnt_in;
         first_row_ff  <= first_row_in;
         row_filter_ff <= row_filter_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psu_recon.sv @@
`default_nettype none

module psu_recon (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  wire psu_pkg::item_type          item,
   input  wire logic [psu_pkg::BYTE_W-1:0] above_byte,
   input  wire logic [psu_pkg::BPP_W-1:0]  pixel_dist,
   output logic                            advance,
   output logic                            wr_en,
   output logic [psu_pkg::COL_W-1:0]       wr_addr,
   output logic [psu_pkg::BYTE_W-1:0]      wr_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [psu_pkg::BYTE_W-1:0]      rsp_pixel_byte,
   output logic                            rsp_row_end,
   output logic                            rsp_bad_filter
);

   logic [psu_pkg::BYTE_W-1:0] left_ff [psu_pkg::PIXEL_BYTES_MAX];
   logic [psu_pkg::BYTE_W-1:0] left_in [psu_pkg::PIXEL_BYTES_MAX];
   logic [psu_pkg::BYTE_W-1:0] ul_ff   [psu_pkg::PIXEL_BYTES_MAX];
   logic [psu_pkg::BYTE_W-1:0] ul_in   [psu_pkg::PIXEL_BYTES_MAX];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [psu_pkg::BYTE_W-1:0]  pixel_ff;
   logic                        row_end_ff, bad_ff;

   logic [psu_pkg::BPP_W-1:0]   bpp_eff;
   logic [psu_pkg::HIST_W-1:0]  hidx;
   logic                        has_left;
   logic [psu_pkg::BYTE_W-1:0]  a, b, c, pred, recon;
   logic [psu_pkg::BYTE_W:0]    avg_sum;
   logic                        bad;

   // Paeth predictor: ties go to left, then above, then above-left
   function automatic logic [psu_pkg::BYTE_W-1:0] paeth_pred(
      input logic [psu_pkg::BYTE_W-1:0] pa_in,
      input logic [psu_pkg::BYTE_W-1:0] pb_in,
      input logic [psu_pkg::BYTE_W-1:0] pc_in
   );
      logic [psu_pkg::BYTE_W+1:0] da, db, dc, ab, cc;
      logic [psu_pkg::BYTE_W-1:0] pick;
      da = (pb_in > pc_in) ? {2'b00, pb_in - pc_in} : {2'b00, pc_in - pb_in};
      db = (pa_in > pc_in) ? {2'b00, pa_in - pc_in} : {2'b00, pc_in - pa_in};
      ab = {2'b00, pa_in} + {2'b00, pb_in};
      cc = {1'b0, pc_in, 1'b0};
      dc = (ab > cc) ? ab - cc : cc - ab;
      if (da <= db && da <= dc) begin
         pick = pa_in;
      end else if (db <= dc) begin
         pick = pb_in;
      end else begin
         pick = pc_in;
      end
      return pick;
   endfunction

   // Move on when no result is due or the output register is free
   assign advance = item_valid && (!item.is_data || !rsp_valid_ff || !rsp_stall);

   // Clamp the pixel distance to 1 .. PIXEL_BYTES_MAX
   always_comb begin
      if (pixel_dist == '0) begin
         bpp_eff = psu_pkg::BPP_W'(1);
      end else if (pixel_dist > psu_pkg::BPP_W'(psu_pkg::PIXEL_BYTES_MAX)) begin
         bpp_eff = psu_pkg::BPP_W'(psu_pkg::PIXEL_BYTES_MAX);
      end else begin
         bpp_eff = pixel_dist;
      end
   end

   // Neighbours and prediction
   always_comb begin
      hidx     = psu_pkg::HIST_W'(bpp_eff - psu_pkg::BPP_W'(1));
      has_left = (item.col >= psu_pkg::COL_W'(bpp_eff));
      b        = item.first_row ? '0 : above_byte;
      a        = has_left ? left_ff[hidx] : '0;
      c        = (has_left && !item.first_row) ? ul_ff[hidx] : '0;
      avg_sum  = {1'b0, a} + {1'b0, b};
      bad      = 1'b0;
      case (item.filt)
         psu_pkg::FILT_NONE:  pred = '0;
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = avg_sum[psu_pkg::BYTE_W:1];
         psu_pkg::FILT_PAETH: pred = paeth_pred(a, b, c);
         default: begin
            pred = '0;
            bad  = 1'b1;
         end
      endcase
      recon = item.data + pred;
   end

   // Write the row back in place of the one above
   assign wr_en   = advance && item.is_data;
   assign wr_addr = item.col;
   assign wr_data = recon;

   // Shift the histories, or drop them at the start of an image
   always_comb begin
      for (int i = 0; i < psu_pkg::PIXEL_BYTES_MAX; i++) begin
         left_in[i] = left_ff[i];
         ul_in[i]   = ul_ff[i];
      end
      if (advance && item.clear_hist) begin
         for (int i = 0; i < psu_pkg::PIXEL_BYTES_MAX; i++) begin
            left_in[i] = '0;
            ul_in[i]   = '0;
         end
      end else if (wr_en) begin
         for (int i = 1; i < psu_pkg::PIXEL_BYTES_MAX; i++) begin
            left_in[i] = left_ff[i-1];
            ul_in[i]   = ul_ff[i-1];
         end
         left_in[0] = recon;
         ul_in[0]   = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psu_pkg::PIXEL_BYTES_MAX; i++) begin
            left_ff[i] <= '0;
            ul_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < psu_pkg::PIXEL_BYTES_MAX; i++) begin
            left_ff[i] <= left_in[i];
            ul_ff[i]   <= ul_in[i];
         end
      end
   end

   // Output register
   always_comb begin
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_ff   <= recon;
         row_end_ff <= item.last;
         bad_ff     <= bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_bad_filter = bad_ff;

endmodule

`default_nettype wire

@@ hw/rtl/png_scanline_unfilter.sv @@
// Channel  Handshake             Payload
// req      req_valid/req_stall   req_data_byte, req_first_of_image
// rsp      rsp_valid/rsp_stall   rsp_pixel_byte, rsp_row_end, rsp_bad_filter
// csr      csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// One byte per cycle sustained while rsp is not stalled. The above-row RAM
// read and the request register share the accepting edge; reconstruction
// then loads the output register once that register is free.
// Filter-type bytes take a slot in the pipeline but produce no response.
// Reset clears control state and the histories; the above-row RAM is not
// cleared, the first-row flag masks its contents.
`default_nettype none

module png_scanline_unfilter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [psu_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                       req_first_of_image,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [psu_pkg::BYTE_W-1:0]      rsp_pixel_byte,
   output logic                            rsp_row_end,
   output logic                            rsp_bad_filter,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [psu_pkg::LEN_W-1:0]  csr_data
);

   logic [psu_pkg::BPP_W-1:0]  bpp_ff;
   logic [psu_pkg::LEN_W-1:0]  len_ff;
   logic                       item_valid;
   psu_pkg::item_type          item;
   logic                       advance;
   logic                       rd_en;
   logic [psu_pkg::COL_W-1:0]  rd_addr;
   logic [psu_pkg::BYTE_W-1:0] rd_data;
   logic                       wr_en;
   logic [psu_pkg::COL_W-1:0]  wr_addr;
   logic [psu_pkg::BYTE_W-1:0] wr_data;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= psu_pkg::BPP_W'(1);
         len_ff <= psu_pkg::LEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            psu_pkg::CSR_BPP: bpp_ff <= csr_data[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_LEN: len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   psu_row_ctrl u_row_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_data_byte      (req_data_byte),
      .req_first_of_image (req_first_of_image),
      .req_stall          (req_stall),
      .row_length         (len_ff),
      .advance            (advance),
      .item_valid_ff      (item_valid),
      .item_ff            (item),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr)
   );

   psu_above_ram u_above_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   psu_recon u_recon (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .above_byte      (rd_data),
      .pixel_dist      (bpp_ff),
      .advance         (advance),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_bad_filter  (rsp_bad_filter)
   );

`ifndef NO_ASSERTIONS
   // A read never lands on the entry being written back in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("above-row read and write collide");

   // A written-back byte is always presented on rsp next cycle
   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid)
      else $error("written byte not presented");

   // req only stalls while a request is held in the pipeline
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && !advance))
      else $error("req stalled with no held request");
`endif

endmodule

`default_nettype wire

@@ dv/unfilter_checker.sv @@
`default_nettype none

module unfilter_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [psu_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                       req_first_of_image,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [psu_pkg::BYTE_W-1:0] rsp_pixel_byte,
   input  wire logic                       rsp_row_end,
   input  wire logic                       rsp_bad_filter,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [psu_pkg::LEN_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [psu_pkg::BYTE_W-1:0] pix;
      logic                       row_end;
      logic                       bad;
   } pixel_result_type;

   // Shadow of the block's state and registers
   logic [psu_pkg::BYTE_W-1:0] above_row [psu_pkg::ROW_BYTES_MAX];
   logic [psu_pkg::BYTE_W-1:0] left_hist [psu_pkg::PIXEL_BYTES_MAX];
   logic [psu_pkg::BYTE_W-1:0] upleft_hist [psu_pkg::PIXEL_BYTES_MAX];
   int                         col_cnt;
   psu_pkg::filt_code_type     row_filt;
   logic                       in_first_row;
   logic [psu_pkg::BPP_W-1:0]  bpp_reg;
   logic [psu_pkg::LEN_W-1:0]  len_reg;

   pixel_result_type           pixels_due [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Reconstruct one accepted request and queue the pixel it yields, if any
   function automatic void reconstruct(input logic [psu_pkg::BYTE_W-1:0] din,
                                       input logic new_image);
      int               bpp, len, col, a, b, c, pa, pb, pc, pred;
      pixel_result_type r;
      if (new_image) begin
         in_first_row = 1'b1;
         col_cnt      = 0;
         left_hist    = '{default: '0};
         upleft_hist  = '{default: '0};
      end
      // filter-type byte: latch the row filter, no pixel
      if (col_cnt == 0) begin
         row_filt = (din > psu_pkg::FILTER_CODE_MAX) ? psu_pkg::FILT_BAD
                                                     : psu_pkg::filt_code_type'(din[2:0]);
         col_cnt  = 1;
         return;
      end
      // clamp the registers to the supported range
      bpp = (bpp_reg == 0) ? 1 : (int'(bpp_reg) > psu_pkg::PIXEL_BYTES_MAX)
                                 ? psu_pkg::PIXEL_BYTES_MAX : int'(bpp_reg);
      len = (len_reg == 0) ? 1 : (int'(len_reg) > psu_pkg::ROW_BYTES_MAX)
                                 ? psu_pkg::ROW_BYTES_MAX : int'(len_reg);
      col = col_cnt - 1;
      if (col >= psu_pkg::ROW_BYTES_MAX) col = psu_pkg::ROW_BYTES_MAX - 1;

      // neighbours, zero where missing
      b = in_first_row ? 0 : int'(above_row[col]);
      a = (col >= bpp) ? int'(left_hist[bpp-1]) : 0;
      c = (col >= bpp && !in_first_row) ? int'(upleft_hist[bpp-1]) : 0;

      pa = (b > c) ? b - c : c - b;
      pb = (a > c) ? a - c : c - a;
      pc = a + b - 2 * c;
      if (pc < 0) pc = -pc;

      r.bad = 1'b0;
      case (row_filt)
         psu_pkg::FILT_NONE:  pred = 0;
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = (a + b) / 2;
         psu_pkg::FILT_PAETH: pred = (pa <= pb && pa <= pc) ? a : (pb <= pc) ? b : c;
         default: begin
            pred  = 0;
            r.bad = 1'b1;
         end
      endcase
      r.pix = psu_pkg::BYTE_W'(int'(din) + pred);

      // advance the histories and the row store
      for (int i = psu_pkg::PIXEL_BYTES_MAX - 1; i > 0; i--) begin
         left_hist[i]   = left_hist[i-1];
         upleft_hist[i] = upleft_hist[i-1];
      end
      left_hist[0]   = r.pix;
      upleft_hist[0] = psu_pkg::BYTE_W'(b);
      above_row[col] = r.pix;

      r.row_end = (col + 1 >= len);
      if (r.row_end) begin
         col_cnt      = 0;
         in_first_row = 1'b0;
      end else begin
         col_cnt = col + 2;
      end
      pixels_due = {pixels_due, r};
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         left_hist    = '{default: '0};
         upleft_hist  = '{default: '0};
         col_cnt      = 0;
         row_filt     = psu_pkg::FILT_NONE;
         in_first_row = 1'b1;
         bpp_reg      = psu_pkg::BPP_W'(1);
         len_reg      = psu_pkg::LEN_W'(1);
         pixels_due.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == psu_pkg::CSR_BPP) bpp_reg = csr_data[psu_pkg::BPP_W-1:0];
            else                               len_reg = csr_data;
         end
         // accepted requests
         if (req_valid && !req_stall) reconstruct(req_data_byte, req_first_of_image);
         // accepted pixels
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               $error("pixel out with none expected: pixel_byte %0h", rsp_pixel_byte);
               fail_count++;
            end else begin
               want = pixels_due.pop_front();
               if (rsp_pixel_byte !== want.pix) begin
                  $error("pixel_byte: expected %0h, got %0h", want.pix, rsp_pixel_byte);
                  fail_count++;
               end
               if (rsp_row_end !== want.row_end) begin
                  $error("row_end: expected %0b, got %0b", want.row_end, rsp_row_end);
                  fail_count++;
               end
               if (rsp_bad_filter !== want.bad) begin
                  $error("bad_filter: expected %0b, got %0b", want.bad, rsp_bad_filter);
                  fail_count++;
               end
            end
         end
      end
      pending = pixels_due.size();
   end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [psu_pkg::BYTE_W-1:0] CODE_BAD_LOW  = psu_pkg::FILTER_CODE_MAX + 8'd1;
   localparam logic [psu_pkg::BYTE_W-1:0] CODE_BAD_HIGH = 8'hFF;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [psu_pkg::BYTE_W-1:0] req_data_byte;
   logic                       req_first_of_image;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [psu_pkg::BYTE_W-1:0] rsp_pixel_byte;
   logic                       rsp_row_end;
   logic                       rsp_bad_filter;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_index;
   logic [psu_pkg::LEN_W-1:0]  csr_data;
   int                         fail_count;
   int                         pending;

   // Stimulus knobs and the stimulus-side view of the row position
   int                         gap_pct;
   int                         stall_pct;
   int                         noise_pct;
   bit                         draining;
   int                         row_col;
   bit                         row_is_first;
   int                         widest;
   logic [psu_pkg::LEN_W-1:0]  len_written;

   png_scanline_unfilter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_of_image (req_first_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_row_end        (rsp_row_end),
      .rsp_bad_filter     (rsp_bad_filter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   unfilter_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_of_image (req_first_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_row_end        (rsp_row_end),
      .rsp_bad_filter     (rsp_bad_filter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Receiver back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !draining && ($urandom_range(99) < stall_pct);
      end
   end

   function automatic int row_len();
      if (len_written == 0) return 1;
      if (int'(len_written) > psu_pkg::ROW_BYTES_MAX) return psu_pkg::ROW_BYTES_MAX;
      return int'(len_written);
   endfunction

   // Send one request, holding it until accepted, and track the row position
   task automatic push_byte(input logic [psu_pkg::BYTE_W-1:0] din, input logic new_image);
      int col;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= din;
      req_first_of_image <= new_image;
      do @(posedge clock); while (req_stall);
      @(negedge clock);

      if (new_image) begin
         row_is_first = 1'b1;
         row_col      = 0;
      end
      if (row_col == 0) begin
         row_col = 1;
      end else begin
         col = row_col - 1;
         if (col + 1 > widest) widest = col + 1;
         if (col + 1 >= row_len()) begin
            row_col      = 0;
            row_is_first = 1'b0;
         end else begin
            row_col = col + 2;
         end
      end
   endtask

   // Random request; never lets a row read above-row entries not yet written
   task automatic random_byte();
      logic [psu_pkg::BYTE_W-1:0] din;
      logic                       new_image;
      if (row_col == 0) begin
         new_image = (!row_is_first && row_len() > widest) || ($urandom_range(99) < 10);
         din = ($urandom_range(9) == 0) ? psu_pkg::BYTE_W'($urandom_range(5, 255))
                                        : psu_pkg::BYTE_W'($urandom_range(4));
      end else begin
         new_image = ($urandom_range(99) < noise_pct);
         din       = psu_pkg::BYTE_W'($urandom);
      end
      push_byte(din, new_image);
   endtask

   // One full row with extreme data bytes
   task automatic put_row(input logic [psu_pkg::BYTE_W-1:0] code, input logic new_image);
      push_byte(code, new_image);
      for (int k = 0; k < row_len(); k++) push_byte(k[0] ? 8'h00 : 8'hFF, 1'b0);
   endtask

   // Drop valid, wait for every pixel, then let the pipeline empty
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      draining = 1'b1;
      repeat (8) @(negedge clock);
      draining = 1'b0;
   endtask

   task automatic write_reg(input logic idx, input logic [psu_pkg::LEN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == psu_pkg::CSR_LEN) len_written = value;
   endtask

   initial begin
      int                        n;
      logic [psu_pkg::LEN_W-1:0] len_val;
      req_valid          = 1'b0;
      req_data_byte      = '0;
      req_first_of_image = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = psu_pkg::CSR_BPP;
      csr_data           = '0;
      draining           = 1'b0;
      gap_pct            = 12;
      stall_pct          = 56;
      noise_pct          = 0;
      row_col            = 0;
      row_is_first       = 1'b1;
      widest             = 0;
      len_written        = psu_pkg::LEN_W'(1);

      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every filter, first row, both invalid extremes
      write_reg(psu_pkg::CSR_BPP, psu_pkg::LEN_W'(1));
      write_reg(psu_pkg::CSR_LEN, psu_pkg::LEN_W'(2));
      put_row(8'(psu_pkg::FILT_PAETH), 1'b1);
      put_row(8'(psu_pkg::FILT_SUB), 1'b0);
      put_row(8'(psu_pkg::FILT_UP), 1'b0);
      put_row(8'(psu_pkg::FILT_AVG), 1'b0);
      put_row(8'(psu_pkg::FILT_PAETH), 1'b0);
      put_row(8'(psu_pkg::FILT_NONE), 1'b0);
      put_row(CODE_BAD_HIGH, 1'b0);
      put_row(CODE_BAD_LOW, 1'b0);
      quiesce();

      // Directed: shorten the row while one is in progress
      write_reg(psu_pkg::CSR_LEN, psu_pkg::LEN_W'(3));
      push_byte(8'(psu_pkg::FILT_UP), 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      quiesce();
      write_reg(psu_pkg::CSR_LEN, psu_pkg::LEN_W'(1));
      push_byte(8'h80, 1'b0);
      quiesce();

      // Random: three idling regimes, several register settings in each
      noise_pct = 3;
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct   = (ph == 0) ? 12 : (ph == 1) ? 56 : 0;
         stall_pct = (ph == 0) ? 56 : (ph == 1) ? 12 : 0;
         for (int s = 0; s < 4; s++) begin
            case ($urandom_range(9))
               0:       len_val = '0;
               1:       len_val = psu_pkg::LEN_W'($urandom_range(20, 40));
               default: len_val = psu_pkg::LEN_W'($urandom_range(1, 8));
            endcase
            write_reg(psu_pkg::CSR_BPP, psu_pkg::LEN_W'($urandom));
            write_reg(psu_pkg::CSR_LEN, len_val);
            n = 0;
            while (n < 28 || row_col != 0) begin
               random_byte();
               n++;
            end
            quiesce();
         end
      end

      // Both registers saturated; close the long row by shortening it
      noise_pct = 0;
      write_reg(psu_pkg::CSR_BPP, psu_pkg::LEN_W'('1));
      write_reg(psu_pkg::CSR_LEN, psu_pkg::LEN_W'('1));
      push_byte(8'(psu_pkg::FILT_PAETH), 1'b1);
      for (int k = 0; k < 12; k++) push_byte(psu_pkg::BYTE_W'($urandom), 1'b0);
      quiesce();
      write_reg(psu_pkg::CSR_LEN, psu_pkg::LEN_W'(1));
      push_byte(8'h5A, 1'b0);
      quiesce();

      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
